// ----- hdl/priority_periodic_task_dispatcher_core_defines.svh -----
// ----------------------------------------------------------------------------
// priority periodic task dispatcher assertion macros
// shared concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PERIODIC_TASK_DISPATCHER_CORE_DEFINES_SVH
`define PRIORITY_PERIODIC_TASK_DISPATCHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppd assertion failed");
// expression must never be true out of reset
`define PPD_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ppd forbidden condition");
`else
`define PPD_ASSERT(label, clk, rst_n, prop)
`define PPD_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- hdl/ppd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg
// types, codes and defaults shared by the task dispatcher modules
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int DEF_MAX_TASKS = 16;
    localparam int QUEUE_DEPTH   = 2;

    // input kind codes
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // internal command codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_REJECT = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  id;
        logic [15:0] period;
        logic [7:0]  prio;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] period;
        logic [7:0]  prio;
        logic [15:0] count;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        logic       run_valid;
        logic [7:0] run_id;
        logic       last;
    } res_t;

endpackage
`default_nettype wire

// ----- hdl/ppd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_front
// input side: decodes the transaction kind and screens create requests
// ----------------------------------------------------------------------------
module ppd_front
(
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    output logic               q_push,
    output ppd_pkg::cmd_t      q_din,
    input  wire logic          q_full
);
    import ppd_pkg::*;

    logic [7:0]  task_id;
    logic [15:0] period;
    logic [7:0]  prio;
    logic [2:0]  op;

    assign task_id = s_tdata[7:0];
    assign period  = s_tdata[23:8];
    assign prio    = s_tdata[31:24];

    // zero period is rejected here so the back end never sees it
    always_comb
    begin
        case (s_tuser)
            KIND_TICK:   op = OP_TICK;
            KIND_CREATE: op = (period == 16'd0) ? OP_REJECT : OP_CREATE;
            KIND_DELETE: op = OP_DELETE;
            KIND_CLEAR:  op = OP_CLEAR;
            default:     op = OP_TICK;
        endcase
    end

    assign s_tready     = !q_full;
    assign q_push       = s_tvalid && !q_full;
    assign q_din.op     = op;
    assign q_din.id     = task_id;
    assign q_din.period = period;
    assign q_din.prio   = prio;

endmodule
`default_nettype wire

// ----- hdl/ppd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module ppd_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ppd_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output ppd_pkg::cmd_t      dout,
    output logic               not_empty
);
    import ppd_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ppd_back.sv -----
`default_nettype none
`include "priority_periodic_task_dispatcher_core_defines.svh"
// ----------------------------------------------------------------------------
// ppd_back
// task table engine: sorted insert, rotating walk for tick and delete
// ----------------------------------------------------------------------------
module ppd_back
#(
    parameter int MAX_TASKS = ppd_pkg::DEF_MAX_TASKS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ppd_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    output ppd_pkg::res_t      res,
    output logic               res_valid,
    input  wire logic          res_ready
);
    import ppd_pkg::*;

    localparam int TOT_W = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [7:0]       id_reg, id_next;
    logic [TOT_W-1:0] rem_reg, rem_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             removed_reg, removed_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_id_reg, pend_id_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;
    entry_t           entry_reg [MAX_TASKS];
    entry_t           entry_next [MAX_TASKS];
    entry_t           prev_ent [MAX_TASKS];
    logic [MAX_TASKS-1:0] gt;
    logic [MAX_TASKS-1:0] gt_prev;

    entry_t      head;
    entry_t      head_upd;
    entry_t      new_ent;
    logic [15:0] cnt_inc;
    logic        due;
    logic        is_tick;
    logic        match;
    logic        walk_emit;
    logic        can_emit;
    logic        step;
    logic        pop;
    logic        walk_start;
    logic        full;
    logic        do_insert;

    assign can_emit   = !out_valid_reg || res_ready;
    assign full       = (total_reg == TOT_W'(MAX_TASKS));
    assign walk_start = ((cmd.op == OP_TICK) || (cmd.op == OP_DELETE)) && (total_reg != '0);
    assign cmd_ready  = (state_reg == S_IDLE) && (walk_start || can_emit);
    assign pop        = cmd_valid && cmd_ready;
    assign do_insert  = pop && (cmd.op == OP_CREATE) && !full;

    // head of the table during a walk
    assign head      = entry_reg[0];
    assign cnt_inc   = head.count + 16'd1;
    assign due       = (cnt_inc == head.period);
    assign is_tick   = (op_reg == OP_TICK);
    assign match     = !is_tick && !removed_reg && (head.id == id_reg);
    assign walk_emit = is_tick && due && pend_valid_reg;
    assign step      = (state_reg == S_WALK) && (!walk_emit || can_emit);

    always_comb
    begin
        head_upd       = head;
        // counters only advance on a tick walk
        if (is_tick)
        begin
            head_upd.count = due ? 16'd0 : cnt_inc;
        end
        new_ent.id     = cmd.id;
        new_ent.period = cmd.period;
        new_ent.prio   = cmd.prio;
        new_ent.count  = 16'd0;
    end

    // per entry compare against the new priority, monotonic on a sorted table
    always_comb
    begin
        prev_ent[0] = new_ent;
        gt_prev[0]  = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            gt[i] = (TOT_W'(i) < total_reg) && (entry_reg[i].prio > cmd.prio);
        end
        for (int i = 1; i < MAX_TASKS; i++)
        begin
            prev_ent[i] = entry_reg[i-1];
            gt_prev[i]  = gt[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (do_insert)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (gt_prev[i])
                begin
                    entry_next[i] = prev_ent[i];
                end
                else if (gt[i] || (TOT_W'(i) == total_reg))
                begin
                    entry_next[i] = new_ent;
                end
            end
        end
        else if (step)
        begin
            // rotate down by one, the head goes back in at the tail unless dropped
            for (int i = 0; i < MAX_TASKS - 1; i++)
            begin
                entry_next[i] = entry_reg[i+1];
            end
            if (!match)
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    if (TOT_W'(i + 1) == total_reg)
                    begin
                        entry_next[i] = head_upd;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        rem_next        = rem_reg;
        total_next      = total_reg;
        removed_next    = removed_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (walk_start)
                    begin
                        state_next      = S_WALK;
                        op_next         = cmd.op;
                        id_next         = cmd.id;
                        rem_next        = total_reg;
                        removed_next    = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_next.status  = ST_OK;
                        out_next.run_valid = 1'b0;
                        out_next.run_id  = 8'd0;
                        out_next.last    = 1'b1;
                        case (cmd.op)
                            OP_CREATE:
                            begin
                                if (full)
                                begin
                                    out_next.status = ST_FULL;
                                end
                                else
                                begin
                                    total_next = total_reg + 1'b1;
                                end
                            end
                            OP_REJECT: out_next.status = ST_INVALID;
                            OP_CLEAR:  total_next = '0;
                            default:   out_next.status = ST_OK;
                        endcase
                    end
                end
            end
            S_WALK:
            begin
                if (step)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (walk_emit)
                    begin
                        out_valid_next     = 1'b1;
                        out_next.status    = ST_OK;
                        out_next.run_valid = 1'b1;
                        out_next.run_id    = pend_id_reg;
                        out_next.last      = 1'b0;
                    end
                    if (is_tick && due)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = head.id;
                    end
                    if (match)
                    begin
                        removed_next = 1'b1;
                        total_next   = total_reg - 1'b1;
                    end
                    if (rem_reg == TOT_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = ST_OK;
                    out_next.run_valid = is_tick && pend_valid_reg;
                    out_next.run_id    = (is_tick && pend_valid_reg) ? pend_id_reg : 8'd0;
                    out_next.last      = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_TICK;
            rem_reg        <= '0;
            total_reg      <= '0;
            removed_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            rem_reg        <= rem_next;
            total_reg      <= total_next;
            removed_reg    <= removed_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        pend_id_reg <= pend_id_next;
        out_reg     <= out_next;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    `PPD_NEVER(a_total_bound, clk, rst_n, total_reg > TOT_W'(MAX_TASKS))
    `PPD_NEVER(a_walk_rem, clk, rst_n, (state_reg == S_WALK) && (rem_reg == '0))
    `PPD_NEVER(a_pend_tick, clk, rst_n, pend_valid_reg && (op_reg != OP_TICK))
    `PPD_ASSERT(a_walk_shrink, clk, rst_n, (state_reg == S_WALK) |=> (total_reg <= $past(total_reg)))

endmodule
`default_nettype wire

// ----- hdl/priority_periodic_task_dispatcher_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// priority_periodic_task_dispatcher_core
// periodic task table kept in priority order, emits due task ids per tick
// ----------------------------------------------------------------------------
// The core holds up to MAX_TASKS periodic tasks sorted by ascending priority
// value (equal priorities stay in creation order). Each input transaction is
// a tick, a create, a delete or a clear. Create, clear, a rejected create and
// any command on an empty table complete without a table walk. A tick or a
// delete on a table of N tasks walks the table once through the single table
// head, one entry per cycle unless the output stalls. A tick gives one output
// transaction per due task in table order (tlast on the final one), or one
// empty transaction when nothing is due. Every other command gives exactly
// one transaction carrying its status. A two-entry command queue lets the
// input keep taking transactions while the table engine is busy, and the
// output is registered.
module priority_periodic_task_dispatcher_core
#(
    parameter int MAX_TASKS = ppd_pkg::DEF_MAX_TASKS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // task_id[7:0], period[23:8], priority_req[31:24]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status[1:0], run_id[9:2], zero fill [15:10]
    output logic             m_tuser,   // run_valid
    output logic             m_tlast
);
    import ppd_pkg::*;

    cmd_t q_din;
    cmd_t q_dout;
    res_t res;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    // front end: decode and screen each input transaction
    ppd_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_din    (q_din),
        .q_full   (q_full)
    );

    // decouples input acceptance from table work
    ppd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_not_empty)
    );

    // back end: table engine with registered output
    ppd_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_dout),
        .cmd_valid (q_not_empty),
        .cmd_ready (q_pop),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    // result packing
    assign m_tdata = {6'd0, res.run_id, res.status};
    assign m_tuser = res.run_valid;
    assign m_tlast = res.last;

endmodule
`default_nettype wire

// ----- bench/priority_periodic_task_dispatcher_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_periodic_task_dispatcher_core_test
// sends ticks and task commands with random gaps on both streams and
// checks every result transaction against a task table kept in the bench
// ----------------------------------------------------------------------------
module priority_periodic_task_dispatcher_core_test;
    import ppd_pkg::*;

    localparam int TABLE_SIZE   = DEF_MAX_TASKS;
    // worst case is far below this: 376 items, 16 results each, long stalls
    localparam int CYCLE_LIMIT  = 1_200_000;
    // a full table walk plus a long output stall
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_BLOCK = 58;

    // ------------------------------------------------------------------------
    // task table tracker: mirrors the table and queues the expected results
    // ------------------------------------------------------------------------
    class task_table_tracker;
        entry_t      slots [TABLE_SIZE];
        int unsigned occupancy;
        res_t        expected_results [$];
        int unsigned mismatches;

        function new();
            occupancy  = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void queue_result(logic [1:0] status, logic valid, logic [7:0] id,
                                   logic last);
            res_t r;
            r.status    = status;
            r.run_valid = valid;
            r.run_id    = id;
            r.last      = last;
            expected_results.push_back(r);
        endfunction

        // update the table for one accepted command and queue its results
        function void apply_command(logic [1:0] kind, logic [7:0] id,
                                    logic [15:0] period, logic [7:0] prio);
            int unsigned           pos;
            int unsigned           due_total;
            int unsigned           emitted;
            logic [TABLE_SIZE-1:0] due;
            logic [1:0]            status;
            case (kind)
                KIND_TICK:
                begin
                    due       = '0;
                    due_total = 0;
                    for (int i = 0; i < occupancy; i++)
                    begin
                        slots[i].count = slots[i].count + 16'd1;
                        if (slots[i].count == slots[i].period)
                        begin
                            slots[i].count = '0;
                            due[i]         = 1'b1;
                            due_total++;
                        end
                    end
                    if (due_total == 0)
                        queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
                    else
                    begin
                        emitted = 0;
                        for (int i = 0; i < occupancy; i++)
                        begin
                            if (due[i])
                            begin
                                emitted++;
                                queue_result(ST_OK, 1'b1, slots[i].id,
                                             emitted == due_total);
                            end
                        end
                    end
                end
                KIND_CREATE:
                begin
                    if (period == 16'd0)
                        status = ST_INVALID;
                    else if (occupancy >= TABLE_SIZE)
                        status = ST_FULL;
                    else
                    begin
                        // stable insert: after every entry with priority <= prio
                        pos = occupancy;
                        while (pos > 0 && slots[pos-1].prio > prio)
                            pos--;
                        for (int i = occupancy; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos].id     = id;
                        slots[pos].period = period;
                        slots[pos].prio   = prio;
                        slots[pos].count  = '0;
                        occupancy++;
                        status = ST_OK;
                    end
                    queue_result(status, 1'b0, 8'd0, 1'b1);
                end
                KIND_DELETE:
                begin
                    for (int i = 0; i < occupancy; i++)
                    begin
                        if (slots[i].id == id)
                        begin
                            for (int j = i; j + 1 < occupancy; j++)
                                slots[j] = slots[j+1];
                            occupancy--;
                            break;
                        end
                    end
                    queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
                end
                default:
                begin
                    occupancy = 0;
                    queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
                end
            endcase
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
                flag_mismatch($sformatf("unexpected result id %0d", got.run_id));
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.run_valid !== want.run_valid)
                    flag_mismatch($sformatf("run_valid %0b, want %0b",
                                            got.run_valid, want.run_valid));
                if (got.run_id !== want.run_id)
                    flag_mismatch($sformatf("run_id %0d, want %0d", got.run_id, want.run_id));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // task_id[7:0], period[23:8], priority_req[31:24]
    logic [1:0]  s_tuser  = '0;     // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // status[1:0], run_id[9:2], zero fill [15:10]
    logic        m_tuser;           // run_valid
    logic        m_tlast;

    task_table_tracker tracker = new();

    // when set, neither side inserts gaps
    logic        steady_mode = 1'b0;
    int unsigned sink_hold   = 0;
    int unsigned cycle_count = 0;
    res_t        observed;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    priority_periodic_task_dispatcher_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // gap length: mostly none or short, now and then long
    function automatic int unsigned idle_span();
        int unsigned roll;
        if (steady_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_hold <= idle_span();
        end
    end

    // a result transaction is taken on every edge with tvalid and tready high
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            observed.status    = m_tdata[1:0];
            observed.run_id    = m_tdata[9:2];
            observed.run_valid = m_tuser;
            observed.last      = m_tlast;
            tracker.check_result(observed);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------

    // one input transaction, then a random gap; valid stays high when no gap
    task automatic send_command(input logic [1:0] kind, input logic [7:0] id,
                                input logic [15:0] period, input logic [7:0] prio);
        int unsigned span;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {prio, period, id};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.apply_command(kind, id, period, prio);
        span = idle_span();
        if (span > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (span) @(posedge clk);
        end
    endtask

    // hold the input until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // small id and priority sets make deletes hit and priorities tie
    task automatic send_random(input int unsigned create_pct);
        int unsigned roll;
        int unsigned pick;
        logic [7:0]  id;
        logic [15:0] period;
        logic [7:0]  prio;
        roll   = $urandom_range(0, 99);
        id     = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
        period = 16'($urandom);
        prio   = 8'($urandom);
        if (roll < create_pct)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                period = 16'd0;
            else if (pick > 2)
                period = 16'($urandom_range(1, 6));
            if ($urandom_range(0, 9) < 7)
                prio = 8'($urandom_range(0, 3));
            send_command(KIND_CREATE, id, period, prio);
        end
        else if (roll < create_pct + 12)
            send_command(KIND_DELETE, id, period, prio);
        else if (roll < create_pct + 14)
            send_command(KIND_CLEAR, id, period, prio);
        else
            send_command(KIND_TICK, id, period, prio);
    endtask

    initial
    begin
        int unsigned create_mix [6];
        create_mix = '{30, 50, 15, 40, 60, 25};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_command(KIND_TICK,   8'd0,   16'd0,     8'd0);    // empty table tick
        send_command(KIND_DELETE, 8'd5,   16'd0,     8'd0);    // absent id
        send_command(KIND_CREATE, 8'd9,   16'd0,     8'd7);    // zero period
        send_command(KIND_CREATE, 8'd0,   16'd1,     8'd0);
        send_command(KIND_CREATE, 8'd255, 16'hFFFF,  8'd255);
        send_command(KIND_CREATE, 8'h5A,  16'd2,     8'd0);    // ties after id 0
        send_command(KIND_CREATE, 8'd0,   16'd3,     8'd128);  // duplicate id
        send_command(KIND_TICK,   8'hFF,  16'hFFFF,  8'hFF);
        send_command(KIND_TICK,   8'd0,   16'd0,     8'd0);
        // fill up to a full table, periods of one make large bursts
        for (int k = 0; k < 12; k++)
            send_command(KIND_CREATE, 8'(16 + k * 19), 16'(1 + k % 3), 8'(k * 23));
        send_command(KIND_CREATE, 8'd77,  16'd4,     8'd1);    // table full
        send_command(KIND_CREATE, 8'd78,  16'd0,     8'd1);    // zero period wins over full
        send_command(KIND_TICK,   8'd0,   16'd0,     8'd0);
        send_command(KIND_DELETE, 8'd0,   16'd0,     8'd0);    // first of the duplicates
        send_command(KIND_TICK,   8'd0,   16'd0,     8'd0);
        send_command(KIND_CLEAR,  8'hA5,  16'h5A5A,  8'h3C);
        send_command(KIND_TICK,   8'd0,   16'd0,     8'd0);

        // sender stands still until the block has drained
        wait_for_results();

        // random part in blocks of varying create pressure
        for (int b = 0; b < 6; b++)
        begin
            steady_mode = (b == 2);
            for (int n = 0; n < RANDOM_BLOCK; n++)
                send_random(create_mix[b]);
            if (b == 2)
                wait_for_results();
        end
        steady_mode = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.flag_mismatch("results still outstanding at end");

        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
